@@ design/tlvd_pkg.sv @@
// Shared types and constants for the TLV message deframer.
// No dependencies; every other design file imports this package.

package tlvd_pkg;

  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam logic [15:0] MAX_LEN_RESET = 16'd64;
  localparam logic [10:0] COUNT_LIMIT   = 11'd1024;
  localparam logic [1:0]  HDR_LAST_BYTE = 2'd3;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_EMPTY   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_LEN_ERR = 3'd3,
    KIND_OVERRUN = 3'd4
  } result_kind_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_SKIP   = 3'b100
  } phase_e;

  // One queue entry holds everything one input word produces: an optional
  // primary result and an optional frame-end result.
  typedef struct packed {
    logic         prim_valid;
    result_kind_e prim_kind;
    logic         tail_valid;
    logic         tail_overrun;
    logic [15:0]  topic;
    logic [15:0]  length;
    logic [7:0]   data;
    logic [15:0]  index;
    logic         last_of_msg;
    logic [10:0]  count;
  } entry_t;

endpackage

@@ design/tlvd_front.sv @@
// Front end of the TLV deframer: header parsing, message tracking and
// classification of each input word into a queue entry. Uses tlvd_pkg.

module tlvd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_of_frame_i,
  output logic             enq_o,
  output tlvd_pkg::entry_t entry_o
);
  import tlvd_pkg::*;

  logic [15:0] max_len_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] topic_q, topic_d;
  logic [15:0] length_q, length_d;
  logic [15:0] seen_q, seen_d;
  logic [10:0] done_q, done_d;
  logic [10:0] done_inc;
  logic        last_byte;

  assign done_inc  = (done_q < COUNT_LIMIT) ? done_q + 11'd1 : done_q;
  assign last_byte = ({1'b0, seen_q} + 17'd1) == {1'b0, length_q};

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    topic_d   = topic_q;
    length_d  = length_q;
    seen_d    = seen_q;
    done_d    = done_q;
    entry_o   = '0;
    entry_o.prim_kind = KIND_DATA;

    case (phase_q)
      PH_HEADER: begin
        if (hdr_cnt_q < 2'd2) begin
          topic_d = {topic_q[7:0], data_byte_i};
        end else begin
          length_d = {length_q[7:0], data_byte_i};
        end
        hdr_cnt_d = hdr_cnt_q + 2'd1;
        if (hdr_cnt_q == HDR_LAST_BYTE) begin
          if (topic_d == 16'd0) begin
            phase_d = PH_SKIP;
          end else if (length_d > max_len_q) begin
            entry_o.prim_valid = 1'b1;
            entry_o.prim_kind  = KIND_LEN_ERR;
            phase_d            = PH_SKIP;
          end else if (length_d == 16'd0) begin
            done_d                = done_inc;
            entry_o.prim_valid    = 1'b1;
            entry_o.prim_kind     = KIND_EMPTY;
            entry_o.last_of_msg   = 1'b1;
          end else begin
            seen_d  = 16'd0;
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        entry_o.prim_valid  = 1'b1;
        entry_o.prim_kind   = KIND_DATA;
        entry_o.data        = data_byte_i;
        entry_o.index       = seen_q;
        entry_o.last_of_msg = last_byte;
        if (last_byte) begin
          done_d  = done_inc;
          phase_d = PH_HEADER;
        end
        seen_d = seen_q + 16'd1;
      end
      PH_SKIP: begin
        phase_d = PH_SKIP;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    entry_o.topic  = topic_d;
    entry_o.length = length_d;
    entry_o.count  = done_d;

    // The last word of a frame closes it and returns parsing to reset state.
    if (last_of_frame_i) begin
      entry_o.tail_valid   = 1'b1;
      entry_o.tail_overrun = (phase_d == PH_DATA);
      phase_d              = PH_HEADER;
      hdr_cnt_d            = 2'd0;
      topic_d              = 16'd0;
      length_d             = 16'd0;
      seen_d               = 16'd0;
      done_d               = 11'd0;
    end
  end

  assign enq_o = accept_i && (entry_o.prim_valid || entry_o.tail_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= 2'd0;
      topic_q   <= 16'd0;
      length_q  <= 16'd0;
      seen_q    <= 16'd0;
      done_q    <= 11'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (accept_i) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        topic_q   <= topic_d;
        length_q  <= length_d;
        seen_q    <= seen_d;
        done_q    <= done_d;
      end
    end
  end

endmodule

@@ design/tlvd_queue.sv @@
// Short entry queue between the deframer front end and back end.
// Uses tlvd_pkg for the entry type.

module tlvd_queue #(
  parameter int unsigned Depth = tlvd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enq_i,
  input  tlvd_pkg::entry_t entry_i,
  input  logic             deq_i,
  output tlvd_pkg::entry_t head_o,
  output logic             full_o,
  output logic             nempty_o
);
  import tlvd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_enq, do_deq;

  assign full_o   = (count_q == CW'(Depth));
  assign nempty_o = (count_q != '0);
  assign do_enq   = enq_i && !full_o;
  assign do_deq   = deq_i && nempty_o;
  assign head_o   = mem_q[rd_ptr_q];

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
    next_ptr = (ptr == AW'(Depth - 1)) ? '0 : ptr + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_enq) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_deq) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_enq && !do_deq) begin
        count_q <= count_q + CW'(1);
      end else if (do_deq && !do_enq) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

@@ design/tlvd_back.sv @@
// Back end of the TLV deframer: unpacks each queue entry into one or two
// result words and drives the result ports. Uses tlvd_pkg.

module tlvd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlvd_pkg::entry_t head_i,
  input  logic             nempty_i,
  input  logic             pop_i,
  output logic             deq_o,
  output logic             empty_o,
  output logic [2:0]       result_kind_o,
  output logic [15:0]      msg_topic_o,
  output logic [15:0]      message_length_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      byte_index_o,
  output logic             last_of_message_o,
  output logic [10:0]      message_count_o,
  output logic             last_result_o
);
  import tlvd_pkg::*;

  logic second_q;
  logic sel_tail;
  logic take;
  logic done_sel;

  // Once the primary word of an entry is taken, the frame-end word follows.
  assign sel_tail = second_q || !head_i.prim_valid;
  assign take     = pop_i && nempty_i;
  assign deq_o    = take && (sel_tail || !head_i.tail_valid);
  assign done_sel = sel_tail && !head_i.tail_overrun;

  assign empty_o           = !nempty_i;
  assign result_kind_o     = sel_tail ? (head_i.tail_overrun ? KIND_OVERRUN : KIND_DONE)
                                      : head_i.prim_kind;
  assign msg_topic_o       = done_sel ? 16'd0 : head_i.topic;
  assign message_length_o  = done_sel ? 16'd0 : head_i.length;
  assign out_byte_o        = sel_tail ? 8'd0 : head_i.data;
  assign byte_index_o      = sel_tail ? 16'd0 : head_i.index;
  assign last_of_message_o = sel_tail ? 1'b0 : head_i.last_of_msg;
  assign message_count_o   = head_i.count;
  assign last_result_o     = sel_tail || !head_i.tail_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
    end else if (deq_o) begin
      second_q <= 1'b0;
    end else if (take) begin
      second_q <= 1'b1;
    end
  end

endmodule

@@ design/tlv_message_deframer.sv @@
// Top level of the TLV message deframer.
// Instantiates tlvd_front, tlvd_queue and tlvd_back; uses tlvd_pkg.

// The deframer takes one payload word per clock cycle, with no gaps needed
// between words, and a word is accepted in the cycle it is pushed unless the
// entry queue (QueueDepth entries) is full. Each accepted word is parsed in
// that same cycle and leaves one queue entry when it gives any result; the
// result side then presents one result per cycle, so a word that gives two
// results (a data word, or a header word with a result, that also ends the
// frame) holds the queue head for two pops. Results appear on the ports in
// the cycle after the word that caused them at the earliest. The maximum
// message length register should be written only while the block is idle.

module tlv_message_deframer #(
  parameter int unsigned QueueDepth = tlvd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_frame_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind_o,
  output logic [15:0] msg_topic_o,
  output logic [15:0] message_length_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] byte_index_o,
  output logic        last_of_message_o,
  output logic [10:0] message_count_o,
  output logic        last_result_o
);
  import tlvd_pkg::*;

  logic   accept;
  logic   enq;
  logic   deq;
  logic   nempty;
  entry_t entry;
  entry_t head;

  assign accept = push && !full;

  tlvd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .last_of_frame_i (last_of_frame_i),
    .enq_o           (enq),
    .entry_o         (entry)
  );

  tlvd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enq_i    (enq),
    .entry_i  (entry),
    .deq_i    (deq),
    .head_o   (head),
    .full_o   (full),
    .nempty_o (nempty)
  );

  tlvd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .nempty_i          (nempty),
    .pop_i             (pop),
    .deq_o             (deq),
    .empty_o           (empty),
    .result_kind_o     (result_kind_o),
    .msg_topic_o       (msg_topic_o),
    .message_length_o  (message_length_o),
    .out_byte_o        (out_byte_o),
    .byte_index_o      (byte_index_o),
    .last_of_message_o (last_of_message_o),
    .message_count_o   (message_count_o),
    .last_result_o     (last_result_o)
  );

  // A word whose results are not finished keeps the result side non-empty.
  a_second_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_result_o) |=> !empty)
    else $error("second result of a word went missing");

  a_non_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != KIND_DATA) |-> (out_byte_o == 8'd0 && byte_index_o == 16'd0))
    else $error("non-data result carries data byte or index");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (message_count_o <= COUNT_LIMIT))
    else $error("message count above saturation limit");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty))
    else $error("queue reports full and empty together");

endmodule
